@@ design/pac_pkg.sv @@
// ----------------------------------------------------------------------------
// pac_pkg
// shared types, field widths and protocol constants of the anomaly classifier
// ----------------------------------------------------------------------------
package pac_pkg;

    // default table sizes
    localparam int DEF_MAX_FILTERS   = 64;
    localparam int DEF_MAX_ANOMALIES = 16;

    // field widths
    localparam int W_ACTION = 2;
    localparam int W_SLOT   = 6;
    localparam int W_OWNER  = 4;
    localparam int W_LABEL  = 16;
    localparam int W_EN     = 4;
    localparam int W_ETHER  = 16;
    localparam int W_PROTO  = 8;
    localparam int W_IP     = 32;
    localparam int W_PORT   = 16;
    localparam int W_TIME   = 52;
    localparam int W_CNT    = 32;
    localparam int W_SCAN   = 7;

    // number of slots an owner field can name
    localparam int OWNER_SPAN = 1 << W_OWNER;

    // register index of the scan length
    localparam int REG_FILTERS_IN_USE = 0;

    // protocol constants
    localparam logic [W_ETHER-1:0] ETHER_IPV4 = 16'h0800;
    localparam logic [W_PROTO-1:0] PROTO_UDP  = 8'd17;
    localparam logic [W_PROTO-1:0] PROTO_TCP  = 8'd6;

    // bit positions in field enables
    localparam int FE_SRC_IP = 0;
    localparam int FE_DST_IP = 1;
    localparam int FE_SPORT  = 2;
    localparam int FE_DPORT  = 3;

    typedef enum logic [W_ACTION-1:0] {
        ACT_FILTER_WR = 2'd0,
        ACT_START_WR  = 2'd1,
        ACT_END_WR    = 2'd2,
        ACT_CLASSIFY  = 2'd3
    } t_action;

    // packet token travelling along the cell row
    typedef struct packed {
        logic                  vld;
        logic                  hit;
        logic [W_OWNER-1:0]    owner;
        logic [W_PROTO-1:0]    proto;
        logic [W_IP-1:0]       sip;
        logic [W_IP-1:0]       dip;
        logic [W_PORT-1:0]     sport;
        logic [W_PORT-1:0]     dport;
        logic [OWNER_SPAN-1:0] win;
    } t_token;

    // filter entry write broadcast to every cell
    typedef struct packed {
        logic               en;
        logic [W_SLOT-1:0]  slot;
        logic [W_OWNER-1:0] owner;
        logic [W_EN-1:0]    enables;
        logic [W_IP-1:0]    sip;
        logic [W_IP-1:0]    dip;
        logic [W_PORT-1:0]  sport;
        logic [W_PORT-1:0]  dport;
    } t_filter_wr;

    // anomaly slot write
    typedef struct packed {
        logic               start_en;
        logic               end_en;
        logic [W_SLOT-1:0]  slot;
        logic [W_LABEL-1:0] label;
        logic [W_TIME-1:0]  tval;
    } t_slot_wr;

endpackage

@@ design/pac_if.sv @@
// ----------------------------------------------------------------------------
// pac_if
// item and result channels of the anomaly classifier
// ----------------------------------------------------------------------------
interface pac_item_if;
    logic                         valid;
    logic                         ready;
    logic [pac_pkg::W_ACTION-1:0] action;
    logic [pac_pkg::W_SLOT-1:0]   slot;
    logic [pac_pkg::W_OWNER-1:0]  owner_slot;
    logic [pac_pkg::W_LABEL-1:0]  anomaly_label;
    logic [pac_pkg::W_EN-1:0]     field_enables;
    logic [pac_pkg::W_ETHER-1:0]  ether_kind;
    logic [pac_pkg::W_PROTO-1:0]  ip_proto;
    logic [pac_pkg::W_IP-1:0]     src_ip;
    logic [pac_pkg::W_IP-1:0]     dst_ip;
    logic [pac_pkg::W_PORT-1:0]   sport;
    logic [pac_pkg::W_PORT-1:0]   dport;
    logic [pac_pkg::W_TIME-1:0]   time_value;

    modport source (
        output valid, action, slot, owner_slot, anomaly_label, field_enables,
               ether_kind, ip_proto, src_ip, dst_ip, sport, dport, time_value,
        input  ready
    );
    modport sink (
        input  valid, action, slot, owner_slot, anomaly_label, field_enables,
               ether_kind, ip_proto, src_ip, dst_ip, sport, dport, time_value,
        output ready
    );
endinterface

interface pac_result_if;
    logic                         valid;
    logic                         ready;
    logic                         is_anomaly;
    logic [pac_pkg::W_LABEL-1:0]  category;
    logic [pac_pkg::W_CNT-1:0]    packet_total;
    logic [pac_pkg::W_CNT-1:0]    match_total;

    modport source (
        output valid, is_anomaly, category, packet_total, match_total,
        input  ready
    );
    modport sink (
        input  valid, is_anomaly, category, packet_total, match_total,
        output ready
    );
endinterface

@@ design/pac_window.sv @@
// ----------------------------------------------------------------------------
// pac_window
// anomaly slot table: time windows and labels, window test for all slots
// ----------------------------------------------------------------------------
module pac_window #(
    parameter int MAX_ANOMALIES = pac_pkg::DEF_MAX_ANOMALIES
) (
    input  logic                               i_clk,
    input  pac_pkg::t_slot_wr                  i_wr,
    input  logic [pac_pkg::W_TIME-1:0]         i_time,
    output logic [pac_pkg::OWNER_SPAN-1:0]     o_win,
    input  logic [pac_pkg::W_OWNER-1:0]        i_owner,
    output logic [pac_pkg::W_LABEL-1:0]        o_label
);

    // only slots an owner field can reach are kept
    localparam int NUM_SLOTS = (MAX_ANOMALIES < pac_pkg::OWNER_SPAN) ?
                               MAX_ANOMALIES : pac_pkg::OWNER_SPAN;

    logic [pac_pkg::W_TIME-1:0]  r_start [NUM_SLOTS];
    logic [pac_pkg::W_TIME-1:0]  r_end   [NUM_SLOTS];
    logic [pac_pkg::W_LABEL-1:0] r_label [NUM_SLOTS];

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (i_wr.start_en && int'(i_wr.slot) == s) begin
                r_start[s] <= i_wr.tval;
                r_label[s] <= i_wr.label;
            end
            if (i_wr.end_en && int'(i_wr.slot) == s) begin
                r_end[s] <= i_wr.tval;
            end
        end
    end

    // open window, both ends exclusive; unreachable slots stay zero
    always_comb begin
        o_win = '0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            o_win[s] = (i_time > r_start[s]) && (i_time < r_end[s]);
        end
    end

    always_comb begin
        o_label = '0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (int'(i_owner) == s) begin
                o_label = r_label[s];
            end
        end
    end

endmodule

@@ design/pac_cell.sv @@
// ----------------------------------------------------------------------------
// pac_cell
// one filter entry: stores the rule and tests the passing packet token
// ----------------------------------------------------------------------------
module pac_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_hold,
    input  logic [pac_pkg::W_SCAN-1:0]  i_scan_len,
    input  pac_pkg::t_filter_wr         i_wr,
    input  pac_pkg::t_token             i_tok,
    output pac_pkg::t_token             o_tok
);

    logic [pac_pkg::W_IP-1:0]    r_sip;
    logic [pac_pkg::W_IP-1:0]    r_dip;
    logic [pac_pkg::W_PORT-1:0]  r_sport;
    logic [pac_pkg::W_PORT-1:0]  r_dport;
    logic [pac_pkg::W_EN-1:0]    r_en;
    logic [pac_pkg::W_OWNER-1:0] r_owner;

    pac_pkg::t_token r_tok;
    pac_pkg::t_token n_tok;

    logic w_addr_ok;
    logic w_port_any;
    logic w_proto_ok;
    logic w_port_ok;
    logic w_scanned;
    logic w_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr.en && int'(i_wr.slot) == CELL_IDX) begin
            r_sip   <= i_wr.sip;
            r_dip   <= i_wr.dip;
            r_sport <= i_wr.sport;
            r_dport <= i_wr.dport;
            r_en    <= i_wr.enables;
            r_owner <= i_wr.owner;
        end
    end

    always_comb begin
        w_addr_ok  = (!r_en[pac_pkg::FE_SRC_IP] || r_sip == i_tok.sip) &&
                     (!r_en[pac_pkg::FE_DST_IP] || r_dip == i_tok.dip);
        w_port_any = r_en[pac_pkg::FE_SPORT] || r_en[pac_pkg::FE_DPORT];
        w_proto_ok = (i_tok.proto == pac_pkg::PROTO_UDP) ||
                     (i_tok.proto == pac_pkg::PROTO_TCP);
        w_port_ok  = (!r_en[pac_pkg::FE_SPORT] || r_sport == i_tok.sport) &&
                     (!r_en[pac_pkg::FE_DPORT] || r_dport == i_tok.dport);
        w_scanned  = int'(i_scan_len) > CELL_IDX;
        w_hit      = i_tok.vld && !i_tok.hit && w_scanned && i_tok.win[r_owner] &&
                     w_addr_ok && (!w_port_any || (w_proto_ok && w_port_ok));

        n_tok = i_tok;
        if (w_hit) begin
            n_tok.hit   = 1'b1;
            n_tok.owner = r_owner;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else if (!i_hold) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

@@ design/packet_anomaly_classifier.sv @@
// ----------------------------------------------------------------------------
// packet_anomaly_classifier
// First-match packet classifier with per-anomaly time windows. Write items
// (filter entry, window start with label, window end) take effect at the edge
// they are accepted and give no result; a classify item for a non-IPv4 frame
// is dropped the same way. An IPv4 classify item passes the head register,
// then a row of MAX_FILTERS cells, one filter entry per cell, moving one cell
// per clock unless the row is held by a full output register; the next item
// is taken once its verdict leaves the row. Write items and dropped frames go
// at one per cycle while no classify item is in the row. The window test for
// all anomaly slots is done once as the item is accepted and travels with it.
// A finished result sits in the output register while new items are accepted.
// Filter and slot tables hold no meaningful data until written.
// ----------------------------------------------------------------------------
module packet_anomaly_classifier #(
    parameter int MAX_FILTERS   = pac_pkg::DEF_MAX_FILTERS,
    parameter int MAX_ANOMALIES = pac_pkg::DEF_MAX_ANOMALIES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pac_item_if.sink            i_item,
    pac_result_if.source        o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    pac_pkg::t_action    w_act;
    logic                w_acc;
    logic                w_cls;
    pac_pkg::t_filter_wr w_fwr;
    pac_pkg::t_slot_wr   w_swr;
    logic [pac_pkg::OWNER_SPAN-1:0] w_win;
    logic [pac_pkg::W_LABEL-1:0]    w_label;

    pac_pkg::t_token r_head;
    pac_pkg::t_token n_head;
    pac_pkg::t_token w_tok [MAX_FILTERS+1];
    pac_pkg::t_token w_last;

    logic w_free;
    logic w_stall;
    logic w_done;
    logic w_cfg_wr;
    logic w_reg_sel;

    logic                        r_busy;
    logic [pac_pkg::W_SCAN-1:0]  r_scan_len;
    logic                        r_out_vld;
    logic                        r_is_anom;
    logic [pac_pkg::W_LABEL-1:0] r_category;
    logic [pac_pkg::W_CNT-1:0]   r_pkt_cnt;
    logic [pac_pkg::W_CNT-1:0]   r_match_cnt;
    logic [pac_pkg::W_CNT-1:0]   n_pkt_cnt;
    logic [pac_pkg::W_CNT-1:0]   n_match_cnt;

    // ---------------- configuration port ----------------
    // register index, taken from paddr[2]
    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[2] == 1'(pac_pkg::REG_FILTERS_IN_USE));
    assign w_cfg_wr  = psel && penable && pwrite && w_reg_sel;
    assign prdata    = w_reg_sel ? {{(32-pac_pkg::W_SCAN){1'b0}}, r_scan_len} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_len <= '0;
        end else if (w_cfg_wr) begin
            r_scan_len <= pwdata[pac_pkg::W_SCAN-1:0];
        end
    end

    // ---------------- item intake ----------------
    // one classify item in the row at a time
    assign i_item.ready = !r_busy;
    assign w_act        = pac_pkg::t_action'(i_item.action);
    assign w_acc        = i_item.valid && i_item.ready;
    assign w_cls        = w_acc && (w_act == pac_pkg::ACT_CLASSIFY) &&
                          (i_item.ether_kind == pac_pkg::ETHER_IPV4);

    // filter write goes to every cell, the addressed one keeps it
    always_comb begin
        w_fwr.en      = w_acc && (w_act == pac_pkg::ACT_FILTER_WR);
        w_fwr.slot    = i_item.slot;
        w_fwr.owner   = i_item.owner_slot;
        w_fwr.enables = i_item.field_enables;
        w_fwr.sip     = i_item.src_ip;
        w_fwr.dip     = i_item.dst_ip;
        w_fwr.sport   = i_item.sport;
        w_fwr.dport   = i_item.dport;
    end

    // window start carries the label, window end only the time
    always_comb begin
        w_swr.start_en = w_acc && (w_act == pac_pkg::ACT_START_WR);
        w_swr.end_en   = w_acc && (w_act == pac_pkg::ACT_END_WR);
        w_swr.slot     = i_item.slot;
        w_swr.label    = i_item.anomaly_label;
        w_swr.tval     = i_item.time_value;
    end

    pac_window #(
        .MAX_ANOMALIES (MAX_ANOMALIES)
    ) u_window (
        .i_clk   (i_clk),
        .i_wr    (w_swr),
        .i_time  (i_item.time_value),
        .o_win   (w_win),
        .i_owner (w_last.owner),
        .o_label (w_label)
    );

    // head token: packet fields plus the window flags of every slot
    always_comb begin
        n_head.vld   = 1'b1;
        n_head.hit   = 1'b0;
        n_head.owner = '0;
        n_head.proto = i_item.ip_proto;
        n_head.sip   = i_item.src_ip;
        n_head.dip   = i_item.dst_ip;
        n_head.sport = i_item.sport;
        n_head.dport = i_item.dport;
        n_head.win   = w_win;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.vld <= 1'b0;
        end else if (w_cls) begin
            r_head <= n_head;
        end else begin
            r_head.vld <= 1'b0;
        end
    end

    // ---------------- cell row ----------------
    // entry order is row order, so the first hit wins and later cells pass it on
    assign w_tok[0] = r_head;

    for (genvar gi = 0; gi < MAX_FILTERS; gi++) begin : g_cell
        pac_cell #(
            .CELL_IDX (gi)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_hold     (w_stall),
            .i_scan_len (r_scan_len),
            .i_wr       (w_fwr),
            .i_tok      (w_tok[gi]),
            .o_tok      (w_tok[gi+1])
        );
    end

    assign w_last = w_tok[MAX_FILTERS];

    // ---------------- result stage ----------------
    // the row holds its token while the output register is still occupied
    assign w_free  = !r_out_vld || o_result.ready;
    assign w_stall = w_last.vld && !w_free;
    assign w_done  = w_last.vld && w_free;

    assign n_pkt_cnt   = r_pkt_cnt + 1'b1;
    assign n_match_cnt = r_match_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_vld   <= 1'b0;
            r_pkt_cnt   <= '0;
            r_match_cnt <= '0;
        end else begin
            if (w_cls) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
            if (w_done) begin
                r_out_vld <= 1'b1;
                r_pkt_cnt <= n_pkt_cnt;
                if (w_last.hit) begin
                    r_match_cnt <= n_match_cnt;
                end
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // label looked up from the owner of the first hit; zero when nothing hit
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_is_anom  <= w_last.hit;
            r_category <= w_last.hit ? w_label : '0;
        end
    end

    // counters only move on a result, so they double as the result fields
    assign o_result.valid        = r_out_vld;
    assign o_result.is_anomaly   = r_is_anom;
    assign o_result.category     = r_category;
    assign o_result.packet_total = r_pkt_cnt;
    assign o_result.match_total  = r_match_cnt;

endmodule
